[hdl/xfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package xfd_pkg;

	// Payload bound as built (payload range 1..32), and the width of payload counts
	localparam int MAX_PAYLOAD_DEF = 32;
	localparam int CNT_W           = 7;

	// Shortest legal length byte: one payload byte plus length and checksum
	localparam logic [7:0] MIN_LEN = 8'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_HDR0 = 2'd0;
	localparam logic [1:0] REG_HDR1 = 2'd1;
	localparam logic [1:0] REG_HDR2 = 2'd2;

	// Frame command handed from the parser to the drain side
	typedef struct packed {
		logic             err;   // checksum mismatch
		logic             bank;  // payload buffer half
		logic [CNT_W-1:0] len;   // payload bytes
	} cmd_t;

	// Drain side hands a buffer half back to the parser
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	typedef enum logic [2:0] {
		FR_HDR0,
		FR_HDR1,
		FR_HDR2,
		FR_LEN,
		FR_PAY,
		FR_CHECK
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SHOW
	} bk_state_t;

endpackage
`default_nettype wire

[hdl/xor_framed_rx_deframer_core.sv]
// Receive side: accepts one byte per cycle while s_tready is high; s_tready drops only when
// the command queue is full or the payload buffer half to be filled is still draining.
// A good frame's command goes through the command queue to the drain side, which shows each
// payload byte on m_tvalid after a registered buffer read (BK_READ, then BK_SHOW until m_tready).
// A checksum error gives one result, which goes from BK_IDLE straight to BK_SHOW with no read.
// arst_n clears parser, queue and drain control and the header registers; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module xor_framed_rx_deframer_core #(
	parameter int MAX_PAYLOAD = xfd_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // [7:0] rx_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,    // [7:0] out_byte
	output logic            m_tuser,    // [0] kind
	output logic            m_tlast,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_addr,
	input  wire logic [7:0] cfg_wdata
);
	import xfd_pkg::*;

	localparam int AW = $clog2(2*MAX_PAYLOAD);

	logic [7:0]    hdr0_q, hdr1_q, hdr2_q;
	logic          push, pop, fifo_full, head_valid;
	cmd_t          push_cmd, head_cmd;
	rel_t          rel;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, rd_data;

	// Header registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_q <= '0;
			hdr1_q <= '0;
			hdr2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_HDR0: hdr0_q <= cfg_wdata;
				REG_HDR1: hdr1_q <= cfg_wdata;
				REG_HDR2: hdr2_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	xfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.hdr0      (hdr0_q),
		.hdr1      (hdr1_q),
		.hdr2      (hdr2_q),
		.fifo_full (fifo_full),
		.push      (push),
		.cmd       (push_cmd),
		.rel       (rel),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	xfd_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (fifo_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Two halves: one filling while the other drains
	xfd_ram #(.WIDTH(8), .DEPTH(2*MAX_PAYLOAD)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	xfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.rel        (rel),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// Parser never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full) else $error("command pushed into full queue");

	// Drain side pops only a present command
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("command popped from empty queue");

	// An error result is a single, final, zero-data transaction
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata == 8'd0))
		else $error("malformed error result");

	// Buffer writes and reads never touch the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("payload buffer overwritten while draining");

endmodule
`default_nettype wire

[hdl/xfd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module xfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; read data holds between reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[hdl/xfd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module xfd_front #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [7:0]                         s_tdata,
	input  wire logic [7:0]                         hdr0,
	input  wire logic [7:0]                         hdr1,
	input  wire logic [7:0]                         hdr2,
	input  wire logic                               fifo_full,
	output logic                                    push,
	output xfd_pkg::cmd_t                           cmd,
	input  wire xfd_pkg::rel_t                      rel,
	output logic                                    wr_en,
	output logic [$clog2(2*MAX_PAYLOAD)-1:0]        wr_addr,
	output logic [7:0]                              wr_data
);
	import xfd_pkg::*;

	localparam int         AW      = $clog2(2*MAX_PAYLOAD);
	localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD + 2);

	fr_state_t        state_q, state_d;
	logic             bank_q;
	logic [1:0]       busy_q;
	logic [CNT_W-1:0] pay_len_q;
	logic [CNT_W-1:0] pay_cnt_q;
	logic [7:0]       xor_q;
	logic             acc;
	logic             len_bad;
	logic [1:0]       rel_mask;
	logic [1:0]       claim_mask;

	// Stall while the buffer half being filled is still draining, or no queue room
	assign s_tready = !busy_q[bank_q] && !fifo_full;
	assign acc      = s_tvalid && s_tready;
	assign len_bad  = (s_tdata < MIN_LEN) || (s_tdata > LEN_MAX);

	// Buffer halves released by the drain side and claimed by a good frame
	assign rel_mask   = {rel.valid && rel.bank, rel.valid && !rel.bank};
	assign claim_mask = {push && !cmd.err && bank_q, push && !cmd.err && !bank_q};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_HDR0: if (acc) begin
				state_d = (s_tdata == hdr0) ? FR_HDR1 : FR_HDR0;
			end
			FR_HDR1: if (acc) begin
				state_d = (s_tdata == hdr1) ? FR_HDR2 : FR_HDR0;
			end
			FR_HDR2: if (acc) begin
				state_d = (s_tdata == hdr2) ? FR_LEN : FR_HDR0;
			end
			FR_LEN: if (acc) begin
				state_d = len_bad ? FR_HDR0 : FR_PAY;
			end
			FR_PAY: if (acc && (pay_cnt_q + CNT_W'(1) == pay_len_q)) begin
				state_d = FR_CHECK;
			end
			FR_CHECK: if (acc) begin
				state_d = FR_HDR0;
			end
			default: state_d = FR_HDR0;
		endcase
	end

	// Outputs: payload write and frame command
	always_comb begin
		wr_en    = acc && (state_q == FR_PAY);
		wr_addr  = (bank_q ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(pay_cnt_q);
		wr_data  = s_tdata;
		push     = acc && (state_q == FR_CHECK);
		cmd.err  = (s_tdata != xor_q);
		cmd.bank = bank_q;
		cmd.len  = pay_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_HDR0;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q    <= 1'b0;
			busy_q    <= '0;
			pay_len_q <= '0;
			pay_cnt_q <= '0;
			xor_q     <= '0;
		end else begin
			busy_q <= (busy_q & ~rel_mask) | claim_mask;
			if (acc && state_q == FR_LEN) begin
				xor_q     <= s_tdata;
				pay_len_q <= CNT_W'(s_tdata - 8'd2);
				pay_cnt_q <= '0;
			end
			if (acc && state_q == FR_PAY) begin
				xor_q     <= xor_q ^ s_tdata;
				pay_cnt_q <= pay_cnt_q + CNT_W'(1);
			end
			// a good frame moves on to the other half
			if (push && !cmd.err) begin
				bank_q <= !bank_q;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/xfd_cmd_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module xfd_cmd_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire xfd_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output xfd_pkg::cmd_t      head_cmd
);
	import xfd_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_cmd   = entry_q[rd_ptr_q];

	// Command entries
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push && !full, pop && head_valid})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/xfd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module xfd_back #(
	parameter int MAX_PAYLOAD = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        head_valid,
	input  wire xfd_pkg::cmd_t               head_cmd,
	output logic                             pop,
	output logic                             rd_en,
	output logic [$clog2(2*MAX_PAYLOAD)-1:0] rd_addr,
	input  wire logic [7:0]                  rd_data,
	output xfd_pkg::rel_t                    rel,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [7:0]                       m_tdata,
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import xfd_pkg::*;

	localparam int AW = $clog2(2*MAX_PAYLOAD);

	bk_state_t        state_q, state_d;
	cmd_t             cur_q;
	logic [CNT_W-1:0] k_q;
	logic             kind_q;
	logic             last_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (head_valid) begin
				state_d = head_cmd.err ? BK_SHOW : BK_READ;
			end
			BK_READ: state_d = BK_SHOW;
			BK_SHOW: if (m_tready) begin
				state_d = last_q ? BK_IDLE : BK_READ;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs: queue pop, buffer read, result and buffer release
	always_comb begin
		pop       = (state_q == BK_IDLE) && head_valid;
		rd_en     = (state_q == BK_READ);
		rd_addr   = (cur_q.bank ? AW'(MAX_PAYLOAD) : AW'(0)) + AW'(k_q);
		m_tvalid  = (state_q == BK_SHOW);
		m_tuser   = kind_q;
		m_tlast   = last_q;
		m_tdata   = kind_q ? 8'd0 : rd_data;
		rel.valid = (state_q == BK_SHOW) && m_tready && last_q && !kind_q;
		rel.bank  = cur_q.bank;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Current command and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			k_q    <= '0;
			kind_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				BK_IDLE: if (head_valid) begin
					cur_q  <= head_cmd;
					k_q    <= '0;
					kind_q <= head_cmd.err;
					last_q <= head_cmd.err;
				end
				BK_READ: begin
					kind_q <= 1'b0;
					last_q <= (k_q + CNT_W'(1) == cur_q.len);
				end
				BK_SHOW: if (m_tready) begin
					k_q <= k_q + CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

	import xfd_pkg::*;

	localparam int         PAY_MAX     = MAX_PAYLOAD_DEF;
	localparam logic [1:0] REG_UNUSED  = 2'd3;   // no register behind this index
	localparam logic       KIND_PAY    = 1'b0;
	localparam logic       KIND_CSUM   = 1'b1;
	localparam int         QUIET_LIMIT = 4000;
	localparam int         HOLD_CYCLES = 600;
	localparam int         N_DIRECTED  = 22;

	// One result of the deframer
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} deframed_t;

	// Directed row: the byte sent and, where obvious, the single result it closes
	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		logic       t_kind;
		logic [7:0] t_byte;
	} row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'h00;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_addr  = 2'd0;
	logic [7:0] cfg_wdata = 8'h00;

	xor_framed_rx_deframer_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the frame parser
	logic [7:0] hdr_byte [3];
	logic [5:0] frame_pos;
	logic [5:0] frame_end;
	logic [7:0] xor_acc;
	logic [7:0] payload_mem [PAY_MAX];

	deframed_t  deframed_q [$];
	int         err_cnt      = 0;
	int         snd_idle_pct = 0;
	int         rcv_idle_pct = 0;
	bit         hold_req     = 1'b0;

	function automatic void restart_hunt();
		frame_pos = '0;
		frame_end = '0;
		xor_acc   = '0;
	endfunction

	function automatic void shadow_cfg(input logic [1:0] addr, input logic [7:0] val);
		case (addr)
			REG_HDR0: hdr_byte[0] = val;
			REG_HDR1: hdr_byte[1] = val;
			REG_HDR2: hdr_byte[2] = val;
			default: ;
		endcase
	endfunction

	// Advance the shadow parser by one received byte; queue results when keep is set
	function automatic void deframe_byte(input logic [7:0] b, input bit keep);
		int n;
		n = 0;
		if (frame_pos < 6'd3) begin
			if (b == hdr_byte[frame_pos[1:0]]) frame_pos = frame_pos + 6'd1;
			else restart_hunt();
		end else if (frame_pos == 6'd3) begin
			if (int'(b) < int'(MIN_LEN) || int'(b) > PAY_MAX + 2) begin
				restart_hunt();
			end else begin
				xor_acc   = b;
				frame_end = b[5:0] + 6'd3;
				frame_pos = 6'd4;
			end
		end else if (frame_pos + 6'd1 < frame_end) begin
			payload_mem[frame_pos - 6'd4] = b;
			xor_acc   = xor_acc ^ b;
			frame_pos = frame_pos + 6'd1;
		end else begin
			// checksum byte closes the frame
			if (b != xor_acc) begin
				if (keep) deframed_q.push_back('{KIND_CSUM, 8'h00, 1'b1});
			end else begin
				n = int'(frame_end) - 5;
				for (int k = 0; k < n; k++) begin
					if (keep) deframed_q.push_back('{KIND_PAY, payload_mem[k], k == n - 1});
				end
			end
			restart_hunt();
		end
	endfunction

	// Offer one byte, wait for the transaction, then update the shadow parser
	task automatic feed_byte(input logic [7:0] b, input bit keep);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		deframe_byte(b, keep);
	endtask

	// Write all header registers plus a throwaway write to the unused index
	task automatic set_headers(input logic [7:0] h0, input logic [7:0] h1,
			input logic [7:0] h2);
		logic [7:0] vals [4];
		logic [1:0] addrs [4];
		vals  = '{h0, h1, h2, 8'($urandom_range(255))};
		addrs = '{REG_HDR0, REG_HDR1, REG_HDR2, REG_UNUSED};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= addrs[i];
			cfg_wdata <= vals[i];
			shadow_cfg(addrs[i], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Let everything drain before touching the registers again
	task automatic drain_out();
		while (deframed_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content, some broken ones and noise
	task automatic run_random(input int budget);
		int         sent;
		int         sel;
		int         len;
		int         cut;
		logic [7:0] p;
		logic [7:0] x;
		sent = 0;
		while (sent < budget) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				if ($urandom_range(9) == 0) len = PAY_MAX + 2;
				else if ($urandom_range(4) == 0) len = $urandom_range(11, PAY_MAX + 2);
				else len = $urandom_range(int'(MIN_LEN), 10);
				for (int i = 0; i < 3; i++) feed_byte(hdr_byte[i], 1'b1);
				feed_byte(8'(len), 1'b1);
				x = 8'(len);
				for (int k = 0; k < len - 2; k++) begin
					p = 8'($urandom_range(255));
					feed_byte(p, 1'b1);
					x = x ^ p;
				end
				if ($urandom_range(4) == 0) x = x ^ 8'($urandom_range(1, 255));
				feed_byte(x, 1'b1);
				sent += len + 2;
			end else if (sel < 85) begin
				cut = $urandom_range(3);
				for (int i = 0; i < cut; i++) feed_byte(hdr_byte[i], 1'b1);
				if (cut < 3) begin
					// wrong header byte
					feed_byte(hdr_byte[cut] ^ 8'($urandom_range(1, 255)), 1'b1);
				end else if ($urandom_range(1) == 0) begin
					feed_byte(8'($urandom_range(0, int'(MIN_LEN) - 1)), 1'b1);
				end else begin
					feed_byte(8'($urandom_range(PAY_MAX + 3, 255)), 1'b1);
				end
				sent += cut + 1;
			end else begin
				cut = $urandom_range(1, 4);
				for (int i = 0; i < cut; i++) feed_byte(8'($urandom_range(255)), 1'b1);
				sent += cut;
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// Output side: check each transaction, then pick next tready
	always @(posedge clk) begin : out_side
		deframed_t want;
		int        hold_left;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (deframed_q.size() == 0) begin
					$display("%0t: unexpected result kind=%0b byte=%02h last=%0b",
						$time, m_tuser, m_tdata, m_tlast);
					err_cnt++;
				end else begin
					want = deframed_q.pop_front();
					if (m_tuser !== want.kind || m_tdata !== want.data
							|| m_tlast !== want.last) begin
						$display("%0t: mismatch expected kind=%0b byte=%02h last=%0b, got kind=%0b byte=%02h last=%0b",
							$time, want.kind, want.data, want.last,
							m_tuser, m_tdata, m_tlast);
						err_cnt++;
					end
				end
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end else begin
			hold_left = 0;
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("xor_framed_rx_deframer_core test failed");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin : stim
		row_t directed_rows [N_DIRECTED];
		directed_rows = '{
			// minimum frame, headers at reset value
			'{8'h00, 1'b0, KIND_PAY, 8'h00}, '{8'h00, 1'b0, KIND_PAY, 8'h00},
			'{8'h00, 1'b0, KIND_PAY, 8'h00}, '{8'h03, 1'b0, KIND_PAY, 8'h00},
			'{8'h7E, 1'b0, KIND_PAY, 8'h00}, '{8'h7D, 1'b1, KIND_PAY, 8'h7E},
			// bad checksum
			'{8'h00, 1'b0, KIND_PAY, 8'h00}, '{8'h00, 1'b0, KIND_PAY, 8'h00},
			'{8'h00, 1'b0, KIND_PAY, 8'h00}, '{8'h03, 1'b0, KIND_PAY, 8'h00},
			'{8'hFF, 1'b0, KIND_PAY, 8'h00}, '{8'h00, 1'b1, KIND_CSUM, 8'h00},
			// length too small
			'{8'h00, 1'b0, KIND_PAY, 8'h00}, '{8'h00, 1'b0, KIND_PAY, 8'h00},
			'{8'h00, 1'b0, KIND_PAY, 8'h00}, '{8'h02, 1'b0, KIND_PAY, 8'h00},
			// length too large
			'{8'h00, 1'b0, KIND_PAY, 8'h00}, '{8'h00, 1'b0, KIND_PAY, 8'h00},
			'{8'h00, 1'b0, KIND_PAY, 8'h00}, '{8'hFF, 1'b0, KIND_PAY, 8'h00},
			// wrong second header byte
			'{8'h00, 1'b0, KIND_PAY, 8'h00}, '{8'h01, 1'b0, KIND_PAY, 8'h00}
		};
		hdr_byte = '{8'h00, 8'h00, 8'h00};
		restart_hunt();
		for (int i = 0; i < PAY_MAX; i++) payload_mem[i] = 8'h00;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, sender rarely idle, receiver often stalls
		snd_idle_pct = 6;
		rcv_idle_pct = 52;
		for (int i = 0; i < N_DIRECTED; i++) begin
			feed_byte(directed_rows[i].rx, !directed_rows[i].typed);
			if (directed_rows[i].typed)
				deframed_q.push_back('{directed_rows[i].t_kind, directed_rows[i].t_byte, 1'b1});
		end
		s_tvalid <= 1'b0;

		drain_out();
		set_headers(8'hFF, 8'h00, 8'hA5);
		run_random(90);

		// Other way round
		drain_out();
		snd_idle_pct = 52;
		rcv_idle_pct = 6;
		set_headers(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		run_random(80);

		// No idling; a long output stall first so the input backs up
		drain_out();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_headers(8'hFF, 8'hFF, 8'hFF);
		hold_req = 1'b1;
		run_random(80);

		drain_out();
		repeat (12) @(posedge clk);
		if (err_cnt == 0) begin
			$display("xor_framed_rx_deframer_core test passed");
		end else begin
			$display("xor_framed_rx_deframer_core test failed");
		end
		$finish;
	end

endmodule
